// ===== hdl/trpg_pkg.sv =====
`timescale 1ns / 1ps

package trpg_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_LOAD_GFX    = 2'd0,
    CMD_LOAD_COLOUR = 2'd1,
    CMD_RENDER      = 2'd2
  } cmd_t;

  localparam int GFX_AW       = 15;
  localparam int REGION_AW    = 12;
  localparam int REGION_SEL_W = GFX_AW - REGION_AW;
  localparam int REGION_DEPTH = 1 << REGION_AW;

  // only the four upper 4K regions are ever fetched by a render
  localparam int                    PLANE_REGIONS      = 4;
  localparam logic [REGION_SEL_W-1:0] FIRST_PLANE_REGION = 3'd4;
  localparam logic [REGION_SEL_W-1:0] REGION_PLANE2      = 3'd6;
  localparam logic [REGION_SEL_W-1:0] REGION_BANK0       = 3'd7;

  localparam logic [7:0] KEY_A = 8'h22;
  localparam logic [7:0] KEY_B = 8'h3F;

  localparam int COLOUR_W      = 5;
  localparam int PEN_IDX_W     = 3;
  localparam int PIXELS        = 1 << PEN_IDX_W;
  localparam int PAL_ROW_COUNT = 1 << COLOUR_W;

  typedef logic [PIXELS-1:0][2:0] pal_row_t;

  function automatic logic [7:0] gfx_key(input logic [REGION_SEL_W-1:0] region);
    logic [7:0] k;
    k = 8'h00;
    if (region == REGION_PLANE2) k = KEY_B;
    else if (region == FIRST_PLANE_REGION || region == REGION_BANK0) k = KEY_A;
    return k;
  endfunction

  // red = bit 0, green = bit 1, blue only with bits 2 and 3 both set
  function automatic logic [2:0] colour_decode(input logic [7:0] raw);
    return {raw[3] & raw[2], raw[1], raw[0]};
  endfunction

  function automatic logic [23:0] colour_rgb(input logic [2:0] c);
    return {{8{c[0]}}, {8{c[1]}}, {8{c[2]}}};
  endfunction

endpackage

// ===== hdl/trpg_if.sv =====
`timescale 1ns / 1ps

interface trpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [14:0] load_address;
  logic [7:0]  load_data;
  logic [7:0]  tile_attribute;
  logic [7:0]  tile_code;
  logic [2:0]  pixel_row;

  modport source (
    output valid, command, load_address, load_data, tile_attribute, tile_code, pixel_row,
    input  ready
  );
  modport sink (
    input  valid, command, load_address, load_data, tile_attribute, tile_code, pixel_row,
    output ready
  );
endinterface

interface trpg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pen;
  logic [23:0] rgb_color;
  logic        last_pixel;

  modport source (output valid, pen, rgb_color, last_pixel, input ready);
  modport sink   (input valid, pen, rgb_color, last_pixel, output ready);
endinterface

// ===== hdl/trpg_gfx_store.sv =====
`timescale 1ns / 1ps

module trpg_gfx_store (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [trpg_pkg::GFX_AW-1:0]                  wr_addr,
  input  logic [7:0]                                   wr_data,
  input  logic                                         rd_en,
  input  logic [trpg_pkg::REGION_AW-1:0]               rd_base,
  output logic [trpg_pkg::PLANE_REGIONS-1:0][7:0]      rd_data
);

  logic [trpg_pkg::REGION_SEL_W-1:0] wr_region;
  logic [7:0]                        wr_plain;

  assign wr_region = wr_addr[trpg_pkg::GFX_AW-1:trpg_pkg::REGION_AW];
  assign wr_plain  = wr_data ^ trpg_pkg::gfx_key(wr_region);

  for (genvar g = 0; g < trpg_pkg::PLANE_REGIONS; g++) begin : g_region
    logic [7:0] mem [0:trpg_pkg::REGION_DEPTH-1];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (wr_en &&
          wr_region == trpg_pkg::FIRST_PLANE_REGION + trpg_pkg::REGION_SEL_W'(g)) begin
        mem[wr_addr[trpg_pkg::REGION_AW-1:0]] <= wr_plain;
      end
      if (rd_en) begin
        rd_r <= mem[rd_base];
      end
    end

    assign rd_data[g] = rd_r;
  end

endmodule

// ===== hdl/tile_row_pixel_generator.sv =====
`timescale 1ns / 1ps

// Tile row pixel generator. Load items (graphics byte, colour prom byte) are written
// to the stores in the cycle they are accepted and produce nothing; graphics bytes are
// decrypted on the way in. A render item produces eight pixels, leftmost first, one per
// cycle while the output is not stalled; the serializer takes the next row only as it
// emits the last pixel of the current one. Loads can be accepted every cycle, also
// while a row is shifted out, unless a render waits in stage 1 behind a full stage 2.
// Renders pass store read, plane select, serializer and output register in order. Both
// store reads happen at accept time, so loads and renders see the stores in item order.
module tile_row_pixel_generator (
  input  logic              clk,
  input  logic              rst_n,
  trpg_in_if.sink           in_ch,
  trpg_out_if.source        out_ch
);

  logic in_fire, is_render;
  logic out_adv, ser_emit, ser_ready, s2_ready, s1_ready;

  // stage 1: store reads
  logic                                        s1_valid_r;
  logic                                        s1_bank_r;
  logic [trpg_pkg::COLOUR_W-1:0]               s1_colour_r;
  trpg_pkg::pal_row_t                          s1_crow_r;
  logic [trpg_pkg::PLANE_REGIONS-1:0][7:0]     gfx_rd;
  logic [trpg_pkg::REGION_AW-1:0]              rd_base;

  // stage 2: plane bytes
  logic                          s2_valid_r;
  logic [7:0]                    s2_p0_r, s2_p1_r, s2_p2_r;
  logic [trpg_pkg::COLOUR_W-1:0] s2_colour_r;
  trpg_pkg::pal_row_t            s2_crow_r;

  // serializer
  logic                            ser_valid_r, ser_valid_nxt;
  logic [trpg_pkg::PEN_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                      sh0_r, sh1_r, sh2_r;
  logic [trpg_pkg::COLOUR_W-1:0]   ser_colour_r;
  trpg_pkg::pal_row_t              ser_crow_r;
  logic [trpg_pkg::PEN_IDX_W-1:0]  pix_idx;
  logic                            ser_last;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_pen_r;
  logic [23:0] out_rgb_r;
  logic        out_last_r;

  // colour store, one row per palette colour
  trpg_pkg::pal_row_t cmem [0:trpg_pkg::PAL_ROW_COUNT-1];

  logic [trpg_pkg::COLOUR_W-1:0] in_colour;
  logic [8:0]                    in_code;

  assign out_adv   = !out_valid_r || out_ch.ready;
  assign ser_last  = cnt_r == trpg_pkg::PEN_IDX_W'(trpg_pkg::PIXELS - 1);
  assign ser_emit  = ser_valid_r && out_adv;
  assign ser_ready = !ser_valid_r || (ser_emit && ser_last);
  assign s2_ready  = !s2_valid_r || ser_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;

  assign in_ch.ready = s1_ready;
  assign in_fire     = in_ch.valid && s1_ready;
  assign is_render   = in_ch.command == trpg_pkg::CMD_RENDER;

  assign in_colour = {in_ch.tile_attribute[7], in_ch.tile_attribute[5:2]};
  assign in_code   = {in_ch.tile_attribute[0] | in_ch.tile_attribute[6], in_ch.tile_code};
  assign rd_base   = {in_code, in_ch.pixel_row};

  trpg_gfx_store u_gfx (
    .clk     (clk),
    .wr_en   (in_fire && in_ch.command == trpg_pkg::CMD_LOAD_GFX),
    .wr_addr (in_ch.load_address),
    .wr_data (in_ch.load_data),
    .rd_en   (in_fire),
    .rd_base (rd_base),
    .rd_data (gfx_rd)
  );

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == trpg_pkg::CMD_LOAD_COLOUR) begin
      cmem[in_ch.load_address[7:3]][in_ch.load_address[2:0]] <=
        trpg_pkg::colour_decode(in_ch.load_data);
    end
    if (in_fire) begin
      s1_crow_r   <= cmem[in_colour];
      s1_bank_r   <= in_ch.tile_attribute[1];
      s1_colour_r <= in_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_fire && is_render;
    end
  end

  // plane select: bank 1 uses three planes, bank 0 a single plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_p0_r     <= s1_bank_r ? gfx_rd[0] : gfx_rd[3];
      s2_p1_r     <= s1_bank_r ? gfx_rd[1] : 8'h00;
      s2_p2_r     <= s1_bank_r ? gfx_rd[2] : 8'h00;
      s2_colour_r <= s1_colour_r;
      s2_crow_r   <= s1_crow_r;
    end
  end

  always_comb begin
    ser_valid_nxt = ser_valid_r;
    cnt_nxt       = cnt_r;
    if (ser_ready) begin
      ser_valid_nxt = s2_valid_r;
      cnt_nxt       = '0;
    end else if (ser_emit) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready) begin
      sh0_r        <= s2_p0_r;
      sh1_r        <= s2_p1_r;
      sh2_r        <= s2_p2_r;
      ser_colour_r <= s2_colour_r;
      ser_crow_r   <= s2_crow_r;
    end else if (ser_emit) begin
      sh0_r <= {sh0_r[6:0], 1'b0};
      sh1_r <= {sh1_r[6:0], 1'b0};
      sh2_r <= {sh2_r[6:0], 1'b0};
    end
  end

  assign pix_idx = {sh2_r[7], sh1_r[7], sh0_r[7]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= ser_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_pen_r  <= {ser_colour_r, pix_idx};
      out_rgb_r  <= trpg_pkg::colour_rgb(ser_crow_r[pix_idx]);
      out_last_r <= ser_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pen        = out_pen_r;
  assign out_ch.rgb_color  = out_rgb_r;
  assign out_ch.last_pixel = out_last_r;

endmodule
